### rtl/tdbh_pkg.sv
// ----------------------------------------------------------------------------
// tdbh_pkg: shared types and constants
// Status codes, command codes, register indexes and arithmetic constants
// of the touch detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbh_pkg;

   typedef enum logic [2:0] {
      ST_OFF     = 3'd0,
      ST_ON      = 3'd1,
      ST_PUSH    = 3'd2,
      ST_RELEASE = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   // command field of an input beat
   localparam logic FUNC_RELOAD = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 12;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_THRESHOLD_ON  = 2'd0;
   localparam csr_index_type CSR_THRESHOLD_OFF = 2'd1;
   localparam csr_index_type CSR_TIMEOUT_EN    = 2'd2;

   // register reset values
   localparam logic [11:0] THRESHOLD_ON_RST  = 12'd60;
   localparam logic [11:0] THRESHOLD_OFF_RST = 12'd20;
   localparam logic        TIMEOUT_EN_RST    = 1'b1;

   // round and hold limits
   localparam logic [3:0] ROUND_LAST = 4'd15;
   localparam logic [7:0] HOLD_MAX   = 8'd255;

   // one result beat handed to the output buffer
   typedef struct packed {
      logic       valid;
      status_type status;
   } rsp_push_type;

endpackage : tdbh_pkg

`default_nettype wire

### rtl/tdbh_req_if.sv
// ----------------------------------------------------------------------------
// tdbh_req_if: input channel
// Valid/ready channel carrying one command bit and one ADC difference.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdbh_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] sample;

   modport source (output valid, output func, output sample, input ready);
   modport sink   (input valid, input func, input sample, output ready);
endinterface : tdbh_req_if

`default_nettype wire

### rtl/tdbh_rsp_if.sv
// ----------------------------------------------------------------------------
// tdbh_rsp_if: result channel
// Valid/ready channel carrying one touch status code.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdbh_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface : tdbh_rsp_if

`default_nettype wire

### rtl/tdbh_out_buf.sv
// ----------------------------------------------------------------------------
// tdbh_out_buf: two-entry result buffer
// Output register plus skid stage; space stays high while the skid is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbh_out_buf (
   input  wire                  clock,
   input  wire                  reset,
   input  tdbh_pkg::rsp_push_type push,
   output logic                 space,
   tdbh_rsp_if.source           rsp
);
   import tdbh_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   status_type main_status_ff, main_status_in;
   status_type skid_status_ff, skid_status_in;
   logic       pop;

   assign pop    = main_valid_ff && rsp.ready;
   assign space  = !skid_valid_ff;
   assign rsp.valid  = main_valid_ff;
   assign rsp.status = main_status_ff;

   always_comb begin
      main_valid_in  = main_valid_ff;
      main_status_in = main_status_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      if (pop && skid_valid_ff) begin
         // advance the skid beat
         main_status_in = skid_status_ff;
         skid_valid_in  = 1'b0;
      end else if (pop || !main_valid_ff) begin
         main_valid_in  = push.valid;
         main_status_in = push.status;
      end else if (push.valid) begin
         // main is stalled: park the new beat
         skid_valid_in  = 1'b1;
         skid_status_in = push.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_status_ff <= main_status_in;
      skid_status_ff <= skid_status_in;
   end

endmodule : tdbh_out_buf

`default_nettype wire

### rtl/touch_detector_baseline_hysteresis.sv
// ----------------------------------------------------------------------------
// touch_detector_baseline_hysteresis: capacitive touch detector
// Sums rounds of sixteen ADC differences, judges them against an IIR
// baseline with on/off hysteresis and reports push, release and timeout.
// ----------------------------------------------------------------------------
//
//   channel  dir  signals                        beat
//   req      in   valid ready func sample        one command or ADC sample
//   rsp      out  valid ready status             one status per finished round
//   csr      in   csr_we csr_index csr_wdata     one register write
//
// The round state updates at the accept edge from one level of add/compare
// logic, so req accepts a beat each cycle while the output buffer has space.
// A round's status lands in a two-entry output buffer; req.ready drops only
// when both entries hold beats that rsp has not taken.
// Reset is synchronous and active high; it clears the round state, the
// baseline and the buffer and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_detector_baseline_hysteresis (
   input  wire                                  clock,
   input  wire                                  reset,
   tdbh_req_if.sink                             req,
   tdbh_rsp_if.source                           rsp,
   input  wire                                  csr_we,
   input  wire [tdbh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [tdbh_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tdbh_pkg::*;

   // configuration registers
   logic [11:0] threshold_on_ff;
   logic [11:0] threshold_off_ff;
   logic        timeout_en_ff;

   // detector state
   logic [15:0] baseline_ff, baseline_in;
   logic        touched_ff, touched_in;
   logic [7:0]  hold_rounds_ff, hold_rounds_in;
   logic [11:0] round_sum_ff, round_sum_in;
   logic [3:0]  round_count_ff, round_count_in;
   logic        reload_pending_ff, reload_pending_in;

   logic               accept;
   logic               space;
   logic [11:0]        sum;
   logic signed [12:0] delta;
   logic signed [12:0] thr_on_s;
   logic signed [12:0] thr_off_s;
   logic [15:0]        baseline_iir;
   logic [15:0]        baseline_load;
   rsp_push_type       push;

   assign req.ready = space;
   assign accept    = req.valid && space;

   // round sum wraps at 12 bits; delta is exact in 13-bit two's complement
   assign sum       = round_sum_ff + {4'd0, req.sample};
   assign delta     = signed'({1'b0, sum}) - signed'({1'b0, baseline_ff[15:4]});
   assign thr_on_s  = signed'({1'b0, threshold_on_ff});
   assign thr_off_s = signed'({1'b0, threshold_off_ff});

   // 1/64 IIR: baseline - baseline/64 + sum/4, wrapping at 16 bits
   assign baseline_iir  = baseline_ff - {6'd0, baseline_ff[15:6]} + {6'd0, sum[11:2]};
   assign baseline_load = {req.sample, 8'd0};

   always_comb begin
      baseline_in       = baseline_ff;
      touched_in        = touched_ff;
      hold_rounds_in    = hold_rounds_ff;
      round_sum_in      = round_sum_ff;
      round_count_in    = round_count_ff;
      reload_pending_in = reload_pending_ff;
      push.valid        = 1'b0;
      push.status       = ST_OFF;

      if (accept) begin
         if (req.func == FUNC_RELOAD) begin
            // command: reload baseline, drop touch, restart the round
            baseline_in       = baseline_load;
            touched_in        = 1'b0;
            round_sum_in      = '0;
            round_count_in    = '0;
            reload_pending_in = 1'b0;
         end else if (reload_pending_ff) begin
            // first sample after a timeout only reloads the baseline
            baseline_in       = baseline_load;
            reload_pending_in = 1'b0;
         end else if (round_count_ff != ROUND_LAST) begin
            round_sum_in   = sum;
            round_count_in = round_count_ff + 4'd1;
         end else begin
            // sixteenth sample: judge the round
            round_sum_in   = '0;
            round_count_in = '0;
            push.valid     = 1'b1;
            if (!touched_ff) begin
               if (delta > thr_on_s) begin
                  touched_in     = 1'b1;
                  hold_rounds_in = '0;
                  push.status    = ST_PUSH;
               end else begin
                  baseline_in = baseline_iir;
                  push.status = ST_OFF;
               end
            end else if (delta < thr_off_s) begin
               touched_in  = 1'b0;
               push.status = ST_RELEASE;
            end else if (timeout_en_ff && hold_rounds_ff == HOLD_MAX) begin
               // hold stays saturated; each later round times out again
               reload_pending_in = 1'b1;
               push.status       = ST_TIMEOUT;
            end else begin
               if (timeout_en_ff) begin
                  hold_rounds_in = hold_rounds_ff + 8'd1;
               end
               push.status = ST_ON;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff       <= '0;
         touched_ff        <= 1'b0;
         hold_rounds_ff    <= '0;
         round_sum_ff      <= '0;
         round_count_ff    <= '0;
         reload_pending_ff <= 1'b0;
      end else begin
         baseline_ff       <= baseline_in;
         touched_ff        <= touched_in;
         hold_rounds_ff    <= hold_rounds_in;
         round_sum_ff      <= round_sum_in;
         round_count_ff    <= round_count_in;
         reload_pending_ff <= reload_pending_in;
      end
   end

   // register writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_on_ff  <= THRESHOLD_ON_RST;
         threshold_off_ff <= THRESHOLD_OFF_RST;
         timeout_en_ff    <= TIMEOUT_EN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD_ON:  threshold_on_ff  <= csr_wdata[11:0];
            CSR_THRESHOLD_OFF: threshold_off_ff <= csr_wdata[11:0];
            CSR_TIMEOUT_EN:    timeout_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tdbh_out_buf u_out_buf (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .space (space),
      .rsp   (rsp)
   );

endmodule : touch_detector_baseline_hysteresis

`default_nettype wire
